[design/adc_channel_conditioner_unit_defines.svh]
// Assertion macros shared by the conditioner modules.
`ifndef ADC_CHANNEL_CONDITIONER_UNIT_DEFINES_SVH
`define ADC_CHANNEL_CONDITIONER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ACC_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
`define ACC_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define ACC_ASSERT_IMP(name, pre, post)
`define ACC_ASSERT_NXT(name, pre, post)
`endif
`endif

[design/acc_pkg.sv]
// Types, constants and helper functions of the ADC channel conditioner.
package acc_pkg;

	localparam int WINDOW_SHIFT = 7;
	localparam int NUM_CURR     = 4;
	localparam int FIDX_W       = 2;
	localparam int MEM_AW       = FIDX_W + WINDOW_SHIFT;
	localparam int MEM_DEPTH    = NUM_CURR << WINDOW_SHIFT;
	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = SAMPLE_W + WINDOW_SHIFT;
	localparam int CH_W         = 4;
	localparam int VALUE_W      = 26;
	localparam int SUPPLY_W     = 16;
	localparam int GAIN_W       = 10;
	localparam int VREF_W       = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;
	localparam int GS_W         = GAIN_W + SUPPLY_W;
	localparam int RAW_W        = SAMPLE_W + 1;
	localparam int PROD_W       = GS_W + 1 + RAW_W;
	localparam int SCALE_SHIFT  = 16;
	localparam int SHIFTED_W    = PROD_W - SCALE_SHIFT;
	localparam int NUM_W        = VREF_W + 1;
	localparam int DIV_CNT_W    = 5;

	localparam logic [SUPPLY_W-1:0] NOMINAL_SUPPLY = SUPPLY_W'(3300);
	localparam logic [VREF_W-1:0]   VREF_RESET     = VREF_W'(4964352);
	localparam logic [GAIN_W-1:0]   CUR_GAIN_RESET = GAIN_W'(40);
	localparam logic [GAIN_W-1:0]   VIN_GAIN_RESET = GAIN_W'(288);
	localparam logic [GAIN_W-1:0]   VPH_GAIN_RESET = GAIN_W'(288);

	localparam logic signed [SHIFTED_W-1:0] VAL_MAX_EXT = SHIFTED_W'((1 << (VALUE_W - 1)) - 1);
	localparam logic signed [SHIFTED_W-1:0] VAL_MIN_EXT = SHIFTED_W'(-(1 << (VALUE_W - 1)));

	localparam logic [CH_W-1:0] CH_REF    = CH_W'(0);
	localparam logic [CH_W-1:0] CH_VIN    = CH_W'(1);
	localparam logic [CH_W-1:0] CH_PH_LO  = CH_W'(2);
	localparam logic [CH_W-1:0] CH_PH_HI  = CH_W'(4);
	localparam logic [CH_W-1:0] CH_CUR_LO = CH_W'(5);
	localparam logic [CH_W-1:0] CH_CUR_HI = CH_W'(8);

	localparam logic [CFG_IDX_W-1:0] CFG_VREF     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_GAIN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_VIN_GAIN = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_VPH_GAIN = CFG_IDX_W'(3);

	typedef enum logic [2:0] {
		KIND_REF,
		KIND_VIN,
		KIND_VPH,
		KIND_CUR,
		KIND_NONE
	} acc_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_WIN,
		ST_MUL_NOW,
		ST_MUL_MEAN,
		ST_FINISH
	} acc_state_t;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic div_step;
		logic win_update;
		logic mul_now;
		logic mul_mean;
		logic load_out;
	} acc_cmd_t;

	typedef struct packed {
		acc_kind_t kind;
		logic      zero_sample;
		logic      div_last;
		logic      out_free;
	} acc_status_t;

	function automatic acc_kind_t acc_kind(input logic [CH_W-1:0] ch);
		acc_kind_t k;
		if (ch == CH_REF) k = KIND_REF;
		else if (ch == CH_VIN) k = KIND_VIN;
		else if (ch >= CH_PH_LO && ch <= CH_PH_HI) k = KIND_VPH;
		else if (ch >= CH_CUR_LO && ch <= CH_CUR_HI) k = KIND_CUR;
		else k = KIND_NONE;
		return k;
	endfunction

	function automatic logic signed [VALUE_W-1:0] acc_clamp(input logic signed [PROD_W-1:0] p);
		logic signed [SHIFTED_W-1:0] t;
		logic signed [VALUE_W-1:0]   r;
		t = p[PROD_W-1:SCALE_SHIFT];
		if (t > VAL_MAX_EXT) r = VALUE_W'(VAL_MAX_EXT);
		else if (t < VAL_MIN_EXT) r = VALUE_W'(VAL_MIN_EXT);
		else r = VALUE_W'(t);
		return r;
	endfunction

endpackage

[design/acc_if.sv]
// Conversion and result channel interfaces of the conditioner.
interface acc_in_if import acc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CH_W-1:0]            channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, channel, sample, input ready);
	modport sink (input valid, channel, sample, output ready);
endinterface

interface acc_out_if import acc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CH_W-1:0]           channel_out;
	logic signed [VALUE_W-1:0] value_now;
	logic signed [VALUE_W-1:0] value_mean;
	logic [SUPPLY_W-1:0]       supply_mv;

	modport source (output valid, channel_out, value_now, value_mean, supply_mv, input ready);
	modport sink (input valid, channel_out, value_now, value_mean, supply_mv, output ready);
endinterface

[design/acc_ctrl.sv]
// Sequencing state machine of the conditioner.
`include "adc_channel_conditioner_unit_defines.svh"

module acc_ctrl import acc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        conv_valid,
	output logic        conv_ready,
	input  acc_status_t st,
	output acc_cmd_t    cmd
);

	acc_state_t state_q;
	acc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (conv_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				case (st.kind)
					KIND_REF: state_d = st.zero_sample ? ST_FINISH : ST_DIV;
					KIND_VIN, KIND_VPH: state_d = ST_MUL_NOW;
					KIND_CUR: state_d = ST_WIN;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_DIV: begin
				if (st.div_last) state_d = ST_FINISH;
			end
			ST_WIN: state_d = ST_MUL_NOW;
			ST_MUL_NOW: begin
				state_d = (st.kind == KIND_CUR) ? ST_MUL_MEAN : ST_FINISH;
			end
			ST_MUL_MEAN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		conv_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				conv_ready  = 1'b1;
				cmd.load_in = conv_valid;
			end
			ST_PREP:     cmd.prep       = 1'b1;
			ST_DIV:      cmd.div_step   = 1'b1;
			ST_WIN:      cmd.win_update = 1'b1;
			ST_MUL_NOW:  cmd.mul_now    = 1'b1;
			ST_MUL_MEAN: cmd.mul_mean   = 1'b1;
			ST_FINISH:   cmd.load_out   = st.out_free;
			default: begin
				cmd        = '0;
				conv_ready = 1'b0;
			end
		endcase
	end

	`ACC_ASSERT_NXT(a_accept_to_prep, conv_valid && conv_ready, state_q == ST_PREP)
	`ACC_ASSERT_IMP(a_load_when_free, cmd.load_out, st.out_free)

endmodule

[design/acc_datapath.sv]
// Divider, window store, scaling multiplier and result register of the conditioner.
`include "adc_channel_conditioner_unit_defines.svh"

module acc_datapath import acc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [CH_W-1:0]            channel,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  acc_cmd_t                   cmd,
	output acc_status_t                st,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [CH_W-1:0]            channel_out,
	output logic signed [VALUE_W-1:0]  value_now,
	output logic signed [VALUE_W-1:0]  value_mean,
	output logic [SUPPLY_W-1:0]        supply_mv
);

	logic [VREF_W-1:0]   vref_q;
	logic [GAIN_W-1:0]   cur_gain_q;
	logic [GAIN_W-1:0]   vin_gain_q;
	logic [GAIN_W-1:0]   vph_gain_q;
	logic [SUPPLY_W-1:0] supply_q;

	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] smp_q;
	acc_kind_t           kind_w;

	logic [NUM_W-1:0]     num_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SAMPLE_W:0]    rem_sh;
	logic                 rem_ge;
	logic [SAMPLE_W:0]    rem_sub;
	logic [NUM_W-1:0]     num_nx;

	logic [SAMPLE_W-1:0]     mem [0:MEM_DEPTH-1];
	logic [SAMPLE_W-1:0]     rdata_q;
	logic [WINDOW_SHIFT-1:0] pos_q [NUM_CURR];
	logic [NUM_CURR-1:0]     wrap_q;
	logic [SUM_W-1:0]        sum_q [NUM_CURR];
	logic [FIDX_W-1:0]       fidx;
	logic [MEM_AW-1:0]       addr;
	logic [SAMPLE_W-1:0]     old_val;
	logic [SUM_W-1:0]        sum_nx;
	logic [SAMPLE_W-1:0]     mean_raw;

	logic [GAIN_W-1:0]          gain_sel;
	logic [GS_W-1:0]            gs_q;
	logic signed [RAW_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_now_q;
	logic signed [PROD_W-1:0]   prod_mean_q;

	logic                      out_valid_q;
	logic [CH_W-1:0]           out_ch_q;
	logic signed [VALUE_W-1:0] out_now_q;
	logic signed [VALUE_W-1:0] out_mean_q;
	logic [SUPPLY_W-1:0]       out_supply_q;
	logic signed [VALUE_W-1:0] now_sel;
	logic signed [VALUE_W-1:0] mean_sel;

	assign kind_w = acc_kind(ch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q     <= VREF_RESET;
			cur_gain_q <= CUR_GAIN_RESET;
			vin_gain_q <= VIN_GAIN_RESET;
			vph_gain_q <= VPH_GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VREF:     vref_q     <= cfg_data[VREF_W-1:0];
				CFG_CUR_GAIN: cur_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_VIN_GAIN: vin_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_VPH_GAIN: vph_gain_q <= cfg_data[GAIN_W-1:0];
				default: vref_q <= vref_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ch_q  <= channel;
			smp_q <= sample;
		end
	end

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, smp_q};
	assign rem_sub = rem_ge ? (rem_sh - {1'b0, smp_q}) : rem_sh;
	assign num_nx  = {num_q[NUM_W-2:0], rem_ge};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_q <= NUM_W'(vref_q) + NUM_W'(smp_q[SAMPLE_W-1:1]);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_nx;
			rem_q <= rem_sub[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			supply_q  <= NOMINAL_SUPPLY;
		end else begin
			if (cmd.prep) begin
				div_cnt_q <= '0;
				if (kind_w == KIND_REF && smp_q == '0) supply_q <= NOMINAL_SUPPLY;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				if (st.div_last) begin
					supply_q <= (num_nx[NUM_W-1:SUPPLY_W] != '0) ? '1 : num_nx[SUPPLY_W-1:0];
				end
			end
		end
	end

	assign fidx     = FIDX_W'(ch_q - CH_CUR_LO);
	assign addr     = {fidx, pos_q[fidx]};
	assign old_val  = wrap_q[fidx] ? rdata_q : '0;
	assign sum_nx   = sum_q[fidx] - {{WINDOW_SHIFT{old_val[SAMPLE_W-1]}}, old_val}
		+ {{WINDOW_SHIFT{smp_q[SAMPLE_W-1]}}, smp_q};
	assign mean_raw = sum_q[fidx][SUM_W-1:WINDOW_SHIFT];

	always_ff @(posedge clk) begin
		if (cmd.win_update) mem[addr] <= smp_q;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= '0;
			for (int i = 0; i < NUM_CURR; i++) begin
				pos_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (cmd.win_update) begin
			sum_q[fidx] <= sum_nx;
			pos_q[fidx] <= pos_q[fidx] + WINDOW_SHIFT'(1);
			if (pos_q[fidx] == '1) wrap_q[fidx] <= 1'b1;
		end
	end

	always_comb begin
		case (kind_w)
			KIND_CUR: gain_sel = cur_gain_q;
			KIND_VIN: gain_sel = vin_gain_q;
			KIND_VPH: gain_sel = vph_gain_q;
			default:  gain_sel = '0;
		endcase
	end

	always_comb begin
		if (cmd.mul_mean) mul_b = {mean_raw[SAMPLE_W-1], mean_raw};
		else if (kind_w == KIND_CUR) mul_b = {smp_q[SAMPLE_W-1], smp_q};
		else mul_b = {1'b0, smp_q};
	end

	assign prod = $signed({1'b0, gs_q}) * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.prep) gs_q <= GS_W'(gain_sel) * GS_W'(supply_q);
		if (cmd.mul_now) prod_now_q <= prod;
		if (cmd.mul_mean) prod_mean_q <= prod;
	end

	always_comb begin
		case (kind_w)
			KIND_REF: begin
				now_sel  = VALUE_W'(supply_q);
				mean_sel = '0;
			end
			KIND_VIN, KIND_VPH: begin
				now_sel  = acc_clamp(prod_now_q);
				mean_sel = '0;
			end
			KIND_CUR: begin
				now_sel  = acc_clamp(prod_now_q);
				mean_sel = acc_clamp(prod_mean_q);
			end
			default: begin
				now_sel  = '0;
				mean_sel = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ch_q     <= ch_q;
			out_now_q    <= now_sel;
			out_mean_q   <= mean_sel;
			out_supply_q <= supply_q;
		end
	end

	assign st.kind        = kind_w;
	assign st.zero_sample = smp_q == '0;
	assign st.div_last    = div_cnt_q == DIV_CNT_W'(NUM_W - 1);
	assign st.out_free    = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign channel_out = out_ch_q;
	assign value_now   = out_now_q;
	assign value_mean  = out_mean_q;
	assign supply_mv   = out_supply_q;

	`ACC_ASSERT_IMP(a_window_only_current, cmd.win_update, kind_w == KIND_CUR)
	`ACC_ASSERT_IMP(a_divide_nonzero, cmd.div_step, smp_q != '0)

endmodule

[design/adc_channel_conditioner_unit.sv]
// Top level of the ADC channel conditioner: controller plus datapath.
//
// conv carries one tagged conversion per beat (channel, sample); result carries
// one beat per conversion (channel_out, value_now, value_mean, supply_mv).
// Registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// 0 vref constant, 1 current gain, 2 input voltage gain, 3 phase voltage gain.
// One conversion is processed at a time; conv.ready is high only between items.
// From an accepted conv beat to result valid, voltage channels take one multiply
// pass, current channels a window read/update and two multiply passes, and the
// reference channel the 25-step restoring divider; a zero reference sample and
// unused codes skip all passes. The controller returns to idle before accepting
// the next beat.
// The result register lets the next conversion be accepted while the last
// result waits; a held result stalls the controller in its final step.
// Reset restores register defaults, supply 3300 mV, empty windows; no
// clearing pass is needed, unfilled window slots read as zero.
module adc_channel_conditioner_unit import acc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	acc_in_if.sink                conv,
	acc_out_if.source             result
);

	acc_cmd_t    cmd;
	acc_status_t st;

	acc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.conv_valid (conv.valid),
		.conv_ready (conv.ready),
		.st         (st),
		.cmd        (cmd)
	);

	acc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.channel     (conv.channel),
		.sample      (conv.sample),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.channel_out (result.channel_out),
		.value_now   (result.value_now),
		.value_mean  (result.value_mean),
		.supply_mv   (result.supply_mv)
	);

endmodule
